@@ rtl/tdb_pkg.sv @@
// shared types and constants of the trail decay blur
package tdb_pkg;

   localparam int GRID_WIDTH  = 32;
   localparam int GRID_HEIGHT = 32;

   localparam int CELL_W     = 24;
   localparam int DECAY_W    = 9;
   localparam int DECAY_FRAC = 8;
   localparam int BLUR_FRAC  = 4;

   localparam int COL_W    = $clog2(GRID_WIDTH);
   localparam int ROW_W    = $clog2(GRID_HEIGHT + 2);
   localparam int COLSUM_W = CELL_W + 2;
   localparam int SUM_W    = CELL_W + BLUR_FRAC;
   localparam int PROD_W   = CELL_W + DECAY_W;

   localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(230);

   localparam logic [COL_W-1:0] LAST_COL  = COL_W'(GRID_WIDTH - 1);
   localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(GRID_HEIGHT - 1);
   localparam logic [ROW_W-1:0] FLUSH_ROW = ROW_W'(GRID_HEIGHT);
   localparam logic [ROW_W-1:0] TAIL_ROW  = ROW_W'(GRID_HEIGHT + 1);

   // two stored rows of one column of the line buffer
   typedef struct packed {
      logic [CELL_W-1:0] row1;
      logic [CELL_W-1:0] row2;
   } pair_type;

   // one column of the 3x3 window
   typedef struct packed {
      logic [CELL_W-1:0] top;
      logic [CELL_W-1:0] mid;
      logic [CELL_W-1:0] bot;
   } column_type;

   // border masks and frame marker of one window position
   typedef struct packed {
      logic mask_top;
      logic mask_bot;
      logic mask_left;
      logic mask_right;
      logic last;
   } tag_type;

endpackage

@@ rtl/tdb_cell.sv @@
// one column cell of the line buffer chain
module tdb_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  tdb_pkg::pair_type d_in,
   output tdb_pkg::pair_type d_out
);

   tdb_pkg::pair_type pair_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pair_ff <= d_in;
      end
   end

   assign d_out = pair_ff;

endmodule

@@ rtl/tdb_blur.sv @@
// weighted sum, decay multiply and saturation pipeline
module tdb_blur (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              win_valid,
   output logic                              win_stall,
   input  tdb_pkg::column_type               col_left,
   input  tdb_pkg::column_type               col_center,
   input  tdb_pkg::column_type               col_right,
   input  tdb_pkg::tag_type                  tag,
   input  logic [tdb_pkg::DECAY_W-1:0]       decay,
   output logic                              out_valid,
   input  logic                              out_stall,
   output logic [tdb_pkg::CELL_W-1:0]        trail_out,
   output logic                              frame_end
);

   function automatic logic [tdb_pkg::COLSUM_W-1:0] col_sum(
      input tdb_pkg::column_type col,
      input logic                mask_top,
      input logic                mask_bot
   );
      logic [tdb_pkg::COLSUM_W-1:0] top_term;
      logic [tdb_pkg::COLSUM_W-1:0] bot_term;
      top_term = mask_top ? '0 : tdb_pkg::COLSUM_W'(col.top);
      bot_term = mask_bot ? '0 : tdb_pkg::COLSUM_W'(col.bot);
      return top_term + tdb_pkg::COLSUM_W'({col.mid, 1'b0}) + bot_term;
   endfunction

   logic                             s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic                             s2_last_ff, s3_last_ff, s4_last_ff, s5_last_ff;
   logic [tdb_pkg::COLSUM_W-1:0]     s2_left_ff, s2_center_ff, s2_right_ff;
   logic [tdb_pkg::COLSUM_W-1:0]     s2_left_in, s2_center_in, s2_right_in;
   logic [tdb_pkg::SUM_W-1:0]        total;
   logic [tdb_pkg::CELL_W-1:0]       s3_sum_ff;
   logic [tdb_pkg::PROD_W-1:0]       s4_prod_ff, s4_prod_in;
   logic [tdb_pkg::CELL_W-1:0]       s5_out_ff, s5_out_in;
   logic                             s2_free, s3_free, s4_free, s5_free;

   assign s5_free   = !s5_valid_ff || !out_stall;
   assign s4_free   = !s4_valid_ff || s5_free;
   assign s3_free   = !s3_valid_ff || s4_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign win_stall = !s2_free;

   // column sums with top and bottom weights 1, middle weight 2
   always_comb begin
      s2_left_in   = tag.mask_left  ? '0 : col_sum(col_left,   tag.mask_top, tag.mask_bot);
      s2_center_in = col_sum(col_center, tag.mask_top, tag.mask_bot);
      s2_right_in  = tag.mask_right ? '0 : col_sum(col_right,  tag.mask_top, tag.mask_bot);
   end

   assign total = tdb_pkg::SUM_W'(s2_left_ff)
                + tdb_pkg::SUM_W'({s2_center_ff, 1'b0})
                + tdb_pkg::SUM_W'(s2_right_ff);

   assign s4_prod_in = tdb_pkg::PROD_W'(s3_sum_ff) * tdb_pkg::PROD_W'(decay);

   // saturate when the scaled value overflows the cell width
   always_comb begin
      if (|s4_prod_ff[tdb_pkg::PROD_W-1:tdb_pkg::CELL_W+tdb_pkg::DECAY_FRAC]) begin
         s5_out_in = '1;
      end else begin
         s5_out_in = s4_prod_ff[tdb_pkg::CELL_W+tdb_pkg::DECAY_FRAC-1:tdb_pkg::DECAY_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s2_free) s2_valid_ff <= win_valid;
         if (s3_free) s3_valid_ff <= s2_valid_ff;
         if (s4_free) s4_valid_ff <= s3_valid_ff;
         if (s5_free) s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_left_ff   <= s2_left_in;
         s2_center_ff <= s2_center_in;
         s2_right_ff  <= s2_right_in;
         s2_last_ff   <= tag.last;
      end
      if (s3_free) begin
         s3_sum_ff  <= total[tdb_pkg::SUM_W-1:tdb_pkg::BLUR_FRAC];
         s3_last_ff <= s2_last_ff;
      end
      if (s4_free) begin
         s4_prod_ff <= s4_prod_in;
         s4_last_ff <= s3_last_ff;
      end
      if (s5_free) begin
         s5_out_ff  <= s5_out_in;
         s5_last_ff <= s4_last_ff;
      end
   end

   assign out_valid = s5_valid_ff;
   assign trail_out = s5_out_ff;
   assign frame_end = s5_last_ff;

endmodule

@@ rtl/trail_decay_blur.sv @@
// top level of the streaming 3x3 blur with decay over a trail grid
//
// req_ carries one trail cell per transaction in raster order, row by row,
// each row left to right, for a GRID_WIDTH by GRID_HEIGHT grid.
// rsp_ returns blurred and decayed cells in raster order, one row plus one
// cell behind the input; rsp_frame_end marks the bottom right cell.
// csr_wr_en with csr_wr_data sets the Q1.8 decay factor (230 after reset);
// the user must write it only while no transaction is in flight, which the
// block itself does not enforce. A result passes the window registers and
// blur stages s2 to s5 on its way to rsp_. One cell is taken per cycle while
// req_stall is low; the rate is set by the line buffer chain, which shifts one
// column cell per accepted cell. After the last cell of a frame the block
// holds req_stall high while GRID_WIDTH + 1 zero cells run through the chain
// to flush the bottom row, then the next frame starts.
// rsp_stall backs up through a five stage elastic pipeline; input is still
// taken as long as some stage is empty.
// Reset clears the counters and valid bits; stored rows are never read
// before they are rewritten, so no clearing pass is needed.
module trail_decay_blur (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tdb_pkg::CELL_W-1:0]   req_trail_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tdb_pkg::CELL_W-1:0]   rsp_trail_out,
   output logic                         rsp_frame_end,
   input  logic                         csr_wr_en,
   input  logic [tdb_pkg::DECAY_W-1:0]  csr_wr_data
);

   // position of the next cell fed into the chain; rows past the grid
   // are the flush rows
   logic [tdb_pkg::COL_W-1:0]    col_ff, col_in;
   logic [tdb_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [tdb_pkg::DECAY_W-1:0]  decay_ff;

   logic                         flushing;
   logic                         fire;
   logic [tdb_pkg::CELL_W-1:0]   feed_data;

   // window position centered one row and one cell behind the feed
   logic                         ctr_valid;
   logic [tdb_pkg::ROW_W-1:0]    ctr_row;
   logic [tdb_pkg::COL_W-1:0]    ctr_col;
   tdb_pkg::tag_type             ctr_tag;

   // line buffer chain
   tdb_pkg::pair_type            cell_q [tdb_pkg::GRID_WIDTH];
   tdb_pkg::pair_type            head;
   tdb_pkg::pair_type            tail;
   tdb_pkg::column_type          new_col;

   // window registers: right is newest column, left is oldest
   tdb_pkg::column_type          right_ff, center_ff, left_ff;
   logic                         s1_valid_ff;
   tdb_pkg::tag_type             s1_tag_ff;
   logic                         s1_free;
   logic                         blur_stall;

   assign flushing  = (row_ff >= tdb_pkg::FLUSH_ROW);
   assign s1_free   = !s1_valid_ff || !blur_stall;
   assign fire      = s1_free && (flushing || req_valid);
   assign req_stall = !s1_free || flushing;
   assign feed_data = flushing ? '0 : req_trail_in;

   // the cell that falls out of the chain is the one GRID_WIDTH feeds back
   assign tail         = cell_q[tdb_pkg::GRID_WIDTH-1];
   assign head.row1    = feed_data;
   assign head.row2    = tail.row1;
   assign new_col.bot  = feed_data;
   assign new_col.mid  = tail.row1;
   assign new_col.top  = tail.row2;

   for (genvar k = 0; k < tdb_pkg::GRID_WIDTH; k++) begin : g_chain
      if (k == 0) begin : g_head
         tdb_cell u_cell (
            .clock    (clock),
            .shift_en (fire),
            .d_in     (head),
            .d_out    (cell_q[k])
         );
      end else begin : g_body
         tdb_cell u_cell (
            .clock    (clock),
            .shift_en (fire),
            .d_in     (cell_q[k-1]),
            .d_out    (cell_q[k])
         );
      end
   end

   // a feed at column zero closes the window on the last column two rows up
   always_comb begin
      if (col_ff != '0) begin
         ctr_valid = (row_ff != '0);
         ctr_row   = row_ff - tdb_pkg::ROW_W'(1);
         ctr_col   = col_ff - tdb_pkg::COL_W'(1);
      end else begin
         ctr_valid = (row_ff >= tdb_pkg::ROW_W'(2));
         ctr_row   = row_ff - tdb_pkg::ROW_W'(2);
         ctr_col   = tdb_pkg::LAST_COL;
      end
      ctr_tag.mask_top   = (ctr_row == '0);
      ctr_tag.mask_bot   = (ctr_row == tdb_pkg::LAST_ROW);
      ctr_tag.mask_left  = (ctr_col == '0);
      ctr_tag.mask_right = (ctr_col == tdb_pkg::LAST_COL);
      ctr_tag.last       = ctr_tag.mask_bot && ctr_tag.mask_right;
   end

   // raster walk, then one flush row plus one cell, then back to the top
   always_comb begin
      priority if (row_ff == tdb_pkg::TAIL_ROW) begin
         row_in = '0;
         col_in = '0;
      end else if (col_ff == tdb_pkg::LAST_COL) begin
         row_in = row_ff + tdb_pkg::ROW_W'(1);
         col_in = '0;
      end else begin
         row_in = row_ff;
         col_in = col_ff + tdb_pkg::COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         decay_ff    <= tdb_pkg::DECAY_RESET;
      end else begin
         if (fire) begin
            col_ff      <= col_in;
            row_ff      <= row_in;
            s1_valid_ff <= ctr_valid;
         end else if (s1_free) begin
            s1_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            decay_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         right_ff  <= new_col;
         center_ff <= right_ff;
         left_ff   <= center_ff;
         s1_tag_ff <= ctr_tag;
      end
   end

   tdb_blur u_blur (
      .clock      (clock),
      .reset      (reset),
      .win_valid  (s1_valid_ff),
      .win_stall  (blur_stall),
      .col_left   (left_ff),
      .col_center (center_ff),
      .col_right  (right_ff),
      .tag        (s1_tag_ff),
      .decay      (decay_ff),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .trail_out  (rsp_trail_out),
      .frame_end  (rsp_frame_end)
   );

   // column counter stays inside the grid
   a_col_range : assert property (@(posedge clock) disable iff (reset)
      col_ff <= tdb_pkg::LAST_COL)
      else $error("column counter out of range");

   // the extra flush cell sits at column zero of the row after the flush row
   a_tail_col : assert property (@(posedge clock) disable iff (reset)
      (row_ff == tdb_pkg::TAIL_ROW) |-> (col_ff == '0))
      else $error("flush tail not at column zero");

   // taking the last cell of a frame starts the flush
   a_flush_start : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && row_ff == tdb_pkg::LAST_ROW
       && col_ff == tdb_pkg::LAST_COL) |=> (row_ff == tdb_pkg::FLUSH_ROW && req_stall))
      else $error("flush did not start after the last cell");

   // the frame marker only sits on the bottom right window
   a_last_corner : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_tag_ff.last) |-> (s1_tag_ff.mask_bot && s1_tag_ff.mask_right))
      else $error("frame end away from the bottom right cell");

endmodule
